### rtl/arcsinh_series_evaluator_top_assert.svh
// Assertion macros for the arcsinh series evaluator checker.
// Needs clk and rst in the scope that uses them.
`ifndef ARCSINH_SERIES_EVALUATOR_TOP_ASSERT_SVH
`define ARCSINH_SERIES_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication
`define ASE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ase_pkg.sv
// Shared constants for the arcsinh series evaluator.
// No dependencies.
package ase_pkg;

  localparam int FRAC_BITS = 30;
  localparam int MAX_TERMS = 64;
  localparam int MAG_W     = 31;
  localparam int XW        = 32;
  localparam int CNT_W     = 7;
  localparam int TOL_W     = 31;
  localparam int DIV_W     = $clog2(2 * MAX_TERMS + 2);
  localparam int CFG_IDX_W = 1;

  localparam logic [MAG_W-1:0] ONE_FIX     = MAG_W'(1) << FRAC_BITS;
  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(1024);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LIMIT = 1'd1;

endpackage

### rtl/ase_mul.sv
// Bit-serial shift-add multiplier returning (a * b) >> FRAC.
// One multiplier bit per cycle; no package dependency.
module ase_mul #(
  parameter int W    = 31,
  parameter int FRAC = 30
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  mcand;
  logic [W-1:0]  mplier;
  logic [W:0]    hi;
  logic [W-1:0]  lo;
  logic [W:0]    acc;
  logic [2*W:0]  full;

  assign acc  = hi + (mplier[0] ? {1'b0, mcand} : '0);
  assign full = {hi, lo};
  assign prod = full[FRAC +: W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      hi     <= '0;
    end else if (cnt != '0) begin
      hi     <= {1'b0, acc[W:1]};
      lo     <= {acc[0], lo[W-1:1]};
      mplier <= {1'b0, mplier[W-1:1]};
    end
  end

endmodule

### rtl/ase_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Narrow divisor; no package dependency.
module ase_div #(
  parameter int W  = 31,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [W-1:0]  quo
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem, quo[W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

### rtl/arcsinh_series_evaluator_top.sv
// Arcsinh series evaluator: asinh(x) in Q2.30 by term recurrence.
// Sequence: a serial multiply forms x*x after the accepting edge; then each term takes a start
// state, then a serial multiply and two serial divides.
// One item at a time: busy is high from accept until the done cycle, so the next item
// can be accepted at the end of the done cycle.
// rst is synchronous: tolerance returns to 1024, term_limit to 64, no item pending.
module arcsinh_series_evaluator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ase_pkg::XW-1:0]   arg_x,
  input  logic                            cfg_we,
  input  logic [ase_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ase_pkg::TOL_W-1:0]       cfg_data,
  output logic                            done,
  output logic signed [ase_pkg::XW-1:0]   result_y,
  output logic [ase_pkg::CNT_W-1:0]       terms_used,
  output logic                            limit_hit
);

  localparam int MW = ase_pkg::MAG_W;
  localparam int XW = ase_pkg::XW;
  localparam int NW = ase_pkg::CNT_W;
  localparam int DW = ase_pkg::DIV_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_X2   = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_MULQ = 3'd3;
  localparam logic [2:0] S_CEIL = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;

  logic [2:0]               state;
  logic [ase_pkg::TOL_W-1:0] tol;
  logic [NW-1:0]            tlim;

  logic          neg;
  logic [MW-1:0] x2;
  logic [MW-1:0] pm;
  logic [MW-1:0] qv;
  logic [XW-1:0] sum;
  logic [NW-1:0] n;
  logic [NW-1:0] limit;

  logic [XW:0]   abs_x;
  logic [MW-1:0] mag_sat;
  logic [XW-1:0] sum_init;
  logic [NW-1:0] lim_sat;
  logic [DW-1:0] two_n;
  logic [DW-1:0] two_n_p1;
  logic [MW-1:0] pm_new;
  logic [XW-1:0] tm_ext;
  logic [XW-1:0] sum_new;
  logic          met;

  logic          mul_start;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic          mul_done;
  logic [MW-1:0] mul_prod;
  logic          div_start;
  logic [MW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [MW-1:0] div_quo;

  ase_mul #(.W(MW), .FRAC(ase_pkg::FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  ase_div #(.W(MW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign busy = state != S_IDLE;

  // |x| saturated to 1.0
  assign abs_x    = arg_x[XW-1] ? ((XW+1)'(0) - {1'b1, arg_x}) : {1'b0, arg_x};
  assign mag_sat  = (abs_x > (XW+1)'(ase_pkg::ONE_FIX)) ? ase_pkg::ONE_FIX
                                                         : abs_x[MW-1:0];
  assign sum_init = arg_x[XW-1] ? (XW'(0) - XW'(mag_sat)) : XW'(mag_sat);
  assign lim_sat  = (tlim == '0) ? NW'(1)
                  : (tlim > NW'(ase_pkg::MAX_TERMS)) ? NW'(ase_pkg::MAX_TERMS) : tlim;

  assign two_n    = DW'({n, 1'b0});
  assign two_n_p1 = two_n | DW'(1);
  assign pm_new   = qv - div_quo;
  assign tm_ext   = XW'(div_quo);
  assign sum_new  = (neg ^ n[0]) ? (sum - tm_ext) : (sum + tm_ext);
  assign met      = div_quo < tol;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = pm;
    mul_b     = x2;
    div_start = 1'b0;
    div_num   = pm_new;
    div_den   = two_n_p1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          mul_start = 1'b1;
          mul_a     = mag_sat;
          mul_b     = mag_sat;
        end
      end
      S_ITER: mul_start = 1'b1;
      S_MULQ: begin
        // ceil(q / 2n) as floor((q + 2n - 1) / 2n)
        div_start = mul_done;
        div_num   = mul_prod + MW'(two_n) - MW'(1);
        div_den   = two_n;
      end
      S_CEIL: div_start = div_done;
      S_X2, S_TERM: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      tol   <= ase_pkg::TOL_RESET;
      tlim  <= ase_pkg::LIMIT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          ase_pkg::REG_TOLERANCE:  tol  <= cfg_data;
          ase_pkg::REG_TERM_LIMIT: tlim <= cfg_data[NW-1:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: if (start) state <= S_X2;
        S_X2:   if (mul_done) state <= S_ITER;
        S_ITER: state <= S_MULQ;
        S_MULQ: if (mul_done) state <= S_CEIL;
        S_CEIL: if (div_done) state <= S_TERM;
        S_TERM: begin
          if (div_done) begin
            if (met || n == limit) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_ITER;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          neg   <= arg_x[XW-1];
          pm    <= mag_sat;
          sum   <= sum_init;
          limit <= lim_sat;
          n     <= '0;
        end
      end
      S_X2:   if (mul_done) x2 <= mul_prod;
      S_ITER: n <= n + 1'b1;
      S_MULQ: if (mul_done) qv <= mul_prod;
      S_CEIL: if (div_done) pm <= pm_new;
      S_TERM: begin
        if (div_done) begin
          sum        <= sum_new;
          result_y   <= sum_new;
          terms_used <= n;
          limit_hit  <= ~met;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/ase_checker.sv
// Port-level checks for the arcsinh series evaluator, bound to the top level.
// Uses arcsinh_series_evaluator_top_assert.svh and ase_pkg.
`include "arcsinh_series_evaluator_top_assert.svh"

module ase_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [ase_pkg::CNT_W-1:0]       terms_used,
  input logic                            limit_hit
);

  localparam logic [ase_pkg::CNT_W-1:0] MAX_N = ase_pkg::CNT_W'(ase_pkg::MAX_TERMS);

  `ASE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ASE_ASSERT_IMP(a_done_after_busy, done, $past(busy) && !busy, "result without pending item")
  `ASE_ASSERT_IMP(a_fell_done, $fell(busy), done, "busy dropped without a result")
  `ASE_ASSERT_IMP(a_terms_range, done, terms_used != '0 && terms_used <= MAX_N, "terms out of range")
  `ASE_ASSERT_IMP(a_hit_known, done, !$isunknown(limit_hit), "limit_hit unknown")

endmodule

bind arcsinh_series_evaluator_top ase_checker u_ase_checker (.*);
